FILE: rtl/core/mhtis_pkg.sv
package mhtis_pkg;

  // table geometry
  localparam int unsigned NUM_BUCKETS  = 16;
  localparam int unsigned BUCKET_DEPTH = 8;

  // field widths
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned CNT_W    = 5;   // bucket count register
  localparam int unsigned BKT_W    = $clog2(NUM_BUCKETS);
  localparam int unsigned SLOT_W   = $clog2(BUCKET_DEPTH);
  localparam int unsigned FILL_W   = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned ADDR_W   = BKT_W + SLOT_W;
  localparam int unsigned BITCNT_W = $clog2(KEY_W);
  localparam int unsigned STATUS_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // request codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // reset value of the bucket count register
  localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = CNT_W'(16);

endpackage

FILE: rtl/core/modulo_hash_table_insert_search.sv
// channel  | direction | signals                                      | transfer
// ---------+-----------+----------------------------------------------+-------------------
// cfg      | in        | cfg_valid_i cfg_ready_o cfg_bucket_count_i   | valid & ready
// request  | in        | in_valid_i in_ready_o operation_i key_i      | valid & ready
// result   | out       | out_valid_o out_ready_i status_o bucket_o    | valid & ready
//          |           | slot_o                                       |
//
// one request at a time: a bit-serial remainder over the key, a decide step,
// then for a search a key RAM read and a compare per bucket entry, then the result.
// the remainder unit is one 6-bit compare and subtract. async active-low reset
// clears fill counts, the bucket count (to 16) and control; key RAM is not cleared.
// a stalled result holds the block until out_ready_i takes it.
module modulo_hash_table_insert_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mhtis_pkg::CNT_W-1:0]     cfg_bucket_count_i,
  // request
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [mhtis_pkg::KEY_W-1:0]     key_i,
  // result
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mhtis_pkg::STATUS_W-1:0]  status_o,
  output logic [mhtis_pkg::BKT_W-1:0]     bucket_o,
  output logic [mhtis_pkg::SLOT_W-1:0]    slot_o
);
  import mhtis_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOD    = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    bucket_count_q;
  logic [CNT_W-1:0]    modulus;
  logic [CNT_W-1:0]    mod_q, mod_d;
  logic                op_q, op_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [KEY_W-1:0]    key_sh_q, key_sh_d;
  logic [BITCNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      trial_sub;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [FILL_W-1:0]   fill_q [NUM_BUCKETS];
  logic [FILL_W-1:0]   cur_fill;
  logic [BKT_W-1:0]    bucket;
  logic                fill_we;
  logic [KEY_W-1:0]    mem [NUM_BUCKETS * BUCKET_DEPTH];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [KEY_W-1:0]    rdata_q;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                last_entry;

  // configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BUCKET_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bucket_count_q <= cfg_bucket_count_i;
    end
  end

  // effective modulus: zero reads as one, saturate at NUM_BUCKETS
  always_comb begin
    modulus = bucket_count_q;
    if (bucket_count_q == '0) begin
      modulus = CNT_W'(1);
    end else if (bucket_count_q > CNT_W'(NUM_BUCKETS)) begin
      modulus = CNT_W'(NUM_BUCKETS);
    end
  end

  // restoring remainder step, one key bit per cycle
  assign trial     = {rem_q, key_sh_q[KEY_W-1]};
  assign trial_sub = trial - {1'b0, mod_q};

  assign bucket     = rem_q[BKT_W-1:0];
  assign cur_fill   = fill_q[bucket];
  assign last_entry = (FILL_W'(idx_q) + FILL_W'(1)) == cur_fill;
  assign mem_waddr  = {bucket, cur_fill[SLOT_W-1:0]};
  assign mem_raddr  = {bucket, idx_q};

  // sequencer
  always_comb begin
    state_d     = state_q;
    mod_d       = mod_q;
    op_d        = op_q;
    key_d       = key_q;
    key_sh_d    = key_sh_q;
    bit_cnt_d   = bit_cnt_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    slot_d      = slot_q;
    mem_we      = 1'b0;
    fill_we     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = operation_i;
          key_d     = key_i;
          key_sh_d  = key_i;
          mod_d     = modulus;
          rem_d     = '0;
          bit_cnt_d = BITCNT_W'(KEY_W - 1);
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        if (trial >= {1'b0, mod_q}) begin
          rem_d = trial_sub[CNT_W-1:0];
        end else begin
          rem_d = trial[CNT_W-1:0];
        end
        key_sh_d  = {key_sh_q[KEY_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BITCNT_W'(1);
        if (bit_cnt_q == '0) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        slot_d = '0;
        idx_d  = '0;
        if (op_q == OP_INSERT) begin
          if (cur_fill >= FILL_W'(BUCKET_DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            mem_we   = 1'b1;
            fill_we  = 1'b1;
            status_d = ST_OK;
            slot_d   = cur_fill[SLOT_W-1:0];
          end
          out_valid_d = 1'b1;
          state_d     = S_DONE;
        end else if (cur_fill == '0) begin
          status_d    = ST_MISS;
          out_valid_d = 1'b1;
          state_d     = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rdata_q == key_q) begin
          status_d    = ST_OK;
          slot_d      = idx_q;
          out_valid_d = 1'b1;
          state_d     = S_DONE;
        end else if (last_entry) begin
          status_d    = ST_MISS;
          out_valid_d = 1'b1;
          state_d     = S_DONE;
        end else begin
          idx_d   = idx_q + SLOT_W'(1);
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mod_q     <= mod_d;
    op_q      <= op_d;
    key_q     <= key_d;
    key_sh_q  <= key_sh_d;
    bit_cnt_q <= bit_cnt_d;
    rem_q     <= rem_d;
    idx_q     <= idx_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
  end

  // per-bucket fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (fill_we) begin
      fill_q[bucket] <= cur_fill + FILL_W'(1);
    end
  end

  // key ram, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= key_q;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign bucket_o    = bucket;
  assign slot_o      = slot_q;

  // a result is never shown while a new request could be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && in_ready_o))
    else $error("result valid while accepting requests");

  // an accepted request starts the remainder loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_MOD)
    else $error("accepted request did not start remainder");

  // the computed bucket lies below the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE |-> rem_q < mod_q)
    else $error("remainder not below modulus");

  // the scan stays inside the filled part of the bucket
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> FILL_W'(idx_q) < cur_fill)
    else $error("scan past bucket fill");

  // dropped and missed requests report slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_MISS) |-> slot_o == '0)
    else $error("nonzero slot on miss or full");

endmodule
